>>> rtl/overwriting_sensor_record_ring_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor record ring
// Short forms for concurrent checks sampled on clk_i, held off during reset.
// ----------------------------------------------------------------------------
`ifndef OVERWRITING_SENSOR_RECORD_RING_ASSERT_SVH
`define OVERWRITING_SENSOR_RECORD_RING_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define OSRR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define OSRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define OSRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/osrr_pkg.sv
// ----------------------------------------------------------------------------
// osrr_pkg
// Shared types and constants of the sensor record ring.
// ----------------------------------------------------------------------------
package osrr_pkg;

  localparam int FieldW    = 16;  // width of one reading value on the ports
  localparam int SelW      = 5;   // width of a sensor number
  localparam int NumValues = 6;   // values per reading
  localparam int StatusW   = 2;
  localparam int TdataW    = 104; // six values and a sensor number, byte padded

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_GET   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

endpackage

>>> rtl/osrr_ram.sv
// ----------------------------------------------------------------------------
// osrr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// The read data holds until the next read.
// ----------------------------------------------------------------------------
module osrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/overwriting_sensor_record_ring.sv
// ----------------------------------------------------------------------------
// overwriting_sensor_record_ring
// Push and clear take one request per cycle while idle and the output is free;
// they give no result. A good get or a pop of a filled ring loads its first
// result through read issue, RAM register and output register; empty and
// bad-index answers load in the cycle after the request. A pop streams one
// result per cycle unless stalled, holding off requests until its last result is
// loaded. Reset (rst_ni low, asynchronous) empties the ring, not the RAM.
// ----------------------------------------------------------------------------
module overwriting_sensor_record_ring #(
  parameter int SLOTS              = 8,
  parameter int SENSORS_PER_RECORD = 17,
  parameter int VALUE_BITS         = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request side
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata, low bit up: pitch_acc, pitch_vel, roll_acc, roll_vel, yaw_acc,
  // yaw_vel (16 each), sensor_select (5), zero pad (3)
  input  logic [osrr_pkg::TdataW-1:0]   s_axis_tdata_i,
  // tuser: opcode (2)
  input  logic [1:0]                    s_axis_tuser_i,
  // Result side
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata, low bit up: out_pitch_acc, out_pitch_vel, out_roll_acc,
  // out_roll_vel, out_yaw_acc, out_yaw_vel (16 each), out_sensor (5), zero pad (3)
  output logic [osrr_pkg::TdataW-1:0]   m_axis_tdata_o,
  // tlast: last_of_run
  output logic                          m_axis_tlast_o,
  // tuser: status (2)
  output logic [osrr_pkg::StatusW-1:0]  m_axis_tuser_o
);

  localparam int PosW   = (SENSORS_PER_RECORD > 1) ? $clog2(SENSORS_PER_RECORD) : 1;
  localparam int SlotW  = $clog2(SLOTS);
  localparam int CntW   = $clog2(SLOTS + 1);
  localparam int Depth  = SLOTS * SENSORS_PER_RECORD;
  localparam int AddrW  = $clog2(Depth);
  localparam int EntryW = osrr_pkg::NumValues * VALUE_BITS;
  localparam int FW     = osrr_pkg::FieldW;
  localparam int SensW  = osrr_pkg::SelW;

  // Ring pointers and fill state
  logic [SlotW-1:0] write_slot_q, write_slot_d;
  logic [SlotW-1:0] oldest_slot_q, oldest_slot_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PosW-1:0]  push_pos_q, push_pos_d;

  // Read run (pop or get) issuing RAM reads
  osrr_pkg::state_e state_q, state_d;
  logic [SlotW-1:0] run_slot_q, run_slot_d;
  logic [PosW-1:0]  run_pos_q, run_pos_d;
  logic [PosW-1:0]  run_end_q, run_end_d;
  logic             run_more_q, run_more_d;

  // Reading waiting in the RAM output register
  logic             pend_q, pend_d;
  logic [PosW-1:0]  pend_pos_q, pend_pos_d;
  logic             pend_last_q, pend_last_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [osrr_pkg::TdataW-1:0]  out_data_q, out_data_d;
  logic                         out_last_q, out_last_d;
  osrr_pkg::status_e            out_status_q, out_status_d;

  // Request decode
  osrr_pkg::op_e     op;
  logic [SensW-1:0]  sel;
  logic              sel_ok;
  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              issue;
  logic              err_load;
  osrr_pkg::status_e err_status;
  logic              run_start;
  logic              is_empty;
  logic              run_last;

  // RAM ports
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  logic [6*FW-1:0]   rd_values;

  logic [SlotW-1:0]  newest_slot;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    return (s == SlotW'(SLOTS - 1)) ? '0 : s + SlotW'(1);
  endfunction

  function automatic logic [AddrW-1:0] entry_addr(input logic [SlotW-1:0] s,
                                                  input logic [PosW-1:0]  p);
    return AddrW'(32'(s) * SENSORS_PER_RECORD + 32'(p));
  endfunction

  assign op       = osrr_pkg::op_e'(s_axis_tuser_i);
  assign sel      = s_axis_tdata_i[6*FW +: SensW];
  assign sel_ok   = 32'(sel) < 32'(SENSORS_PER_RECORD);
  assign is_empty = (count_q == '0);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = pend_q && out_free;
  assign run_last = (run_pos_q == run_end_q);

  assign newest_slot = (write_slot_q == '0) ? SlotW'(SLOTS - 1) : write_slot_q - SlotW'(1);

  // Start a read run for a pop of a filled ring or a good get
  assign run_start = ((op == osrr_pkg::OP_POP) && !is_empty) ||
                     ((op == osrr_pkg::OP_GET) && sel_ok && !is_empty);

  // Requests answered at once with a zero reading and an error status
  always_comb begin
    err_load   = 1'b0;
    err_status = osrr_pkg::STATUS_OK;
    if (accept) begin
      if ((op == osrr_pkg::OP_GET) && !sel_ok) begin
        err_load   = 1'b1;
        err_status = osrr_pkg::STATUS_BAD_INDEX;
      end else if (((op == osrr_pkg::OP_GET) || (op == osrr_pkg::OP_POP)) && is_empty) begin
        err_load   = 1'b1;
        err_status = osrr_pkg::STATUS_EMPTY;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      osrr_pkg::S_IDLE: begin
        if (accept && run_start) begin
          state_d = osrr_pkg::S_RUN;
        end
      end
      osrr_pkg::S_RUN: begin
        // Leave once the final reading of the run moves to the output
        if (out_load && pend_last_q) begin
          state_d = osrr_pkg::S_IDLE;
        end
      end
      default: state_d = osrr_pkg::S_IDLE;
    endcase
  end

  // State outputs: request ready and RAM read issue
  always_comb begin
    s_axis_tready_o = 1'b0;
    issue           = 1'b0;
    unique case (state_q)
      osrr_pkg::S_IDLE: begin
        s_axis_tready_o = out_free;
      end
      osrr_pkg::S_RUN: begin
        // Read the next reading when the RAM output slot is empty or drains now
        issue = run_more_q && (!pend_q || out_load);
      end
      default: begin
        s_axis_tready_o = 1'b0;
        issue           = 1'b0;
      end
    endcase
  end

  // Push writes: sign-extend each 16-bit value, cut to VALUE_BITS; reads extend back
  for (genvar k = 0; k < osrr_pkg::NumValues; k++) begin : g_val
    logic [FW-1:0]         in_v;
    logic [VALUE_BITS-1:0] rd_v;
    assign in_v = s_axis_tdata_i[k*FW +: FW];
    assign ram_wdata[k*VALUE_BITS +: VALUE_BITS] =
      VALUE_BITS'({{VALUE_BITS{in_v[FW-1]}}, in_v});
    assign rd_v = ram_rdata[k*VALUE_BITS +: VALUE_BITS];
    assign rd_values[k*FW +: FW] = FW'({{FW{rd_v[VALUE_BITS-1]}}, rd_v});
  end

  assign ram_we    = accept && (op == osrr_pkg::OP_PUSH);
  assign ram_waddr = entry_addr(write_slot_q, push_pos_q);
  assign ram_re    = issue;
  assign ram_raddr = entry_addr(run_slot_q, run_pos_q);

  // Pointer, run and output register updates
  always_comb begin
    write_slot_d  = write_slot_q;
    oldest_slot_d = oldest_slot_q;
    count_d       = count_q;
    push_pos_d    = push_pos_q;
    run_slot_d    = run_slot_q;
    run_pos_d     = run_pos_q;
    run_end_d     = run_end_q;
    run_more_d    = run_more_q;
    pend_d        = pend_q;
    pend_pos_d    = pend_pos_q;
    pend_last_d   = pend_last_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    out_status_d  = out_status_q;

    if (accept) begin
      unique case (op)
        osrr_pkg::OP_PUSH: begin
          // First reading into a full ring: drop the oldest measurement
          if ((push_pos_q == '0) && (count_q == CntW'(SLOTS))) begin
            oldest_slot_d = slot_inc(oldest_slot_q);
            count_d       = CntW'(SLOTS - 1);
          end
          if (push_pos_q == PosW'(SENSORS_PER_RECORD - 1)) begin
            // Commit the measurement
            push_pos_d   = '0;
            write_slot_d = slot_inc(write_slot_q);
            if (count_d < CntW'(SLOTS)) begin
              count_d = count_d + CntW'(1);
            end
          end else begin
            push_pos_d = push_pos_q + PosW'(1);
          end
        end
        osrr_pkg::OP_POP: begin
          if (!is_empty) begin
            run_slot_d    = oldest_slot_q;
            run_pos_d     = '0;
            run_end_d     = PosW'(SENSORS_PER_RECORD - 1);
            run_more_d    = 1'b1;
            oldest_slot_d = slot_inc(oldest_slot_q);
            count_d       = count_q - CntW'(1);
          end
        end
        osrr_pkg::OP_GET: begin
          if (sel_ok && !is_empty) begin
            run_slot_d = newest_slot;
            run_pos_d  = PosW'(sel);
            run_end_d  = PosW'(sel);
            run_more_d = 1'b1;
          end
        end
        osrr_pkg::OP_CLEAR: begin
          write_slot_d  = '0;
          oldest_slot_d = '0;
          count_d       = '0;
          push_pos_d    = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end

    // Advance the read run
    if (issue) begin
      pend_pos_d  = run_pos_q;
      pend_last_d = run_last;
      if (run_last) begin
        run_more_d = 1'b0;
      end else begin
        run_pos_d = run_pos_q + PosW'(1);
      end
    end

    if (issue) begin
      pend_d = 1'b1;
    end else if (out_load) begin
      pend_d = 1'b0;
    end

    // Output register: drop on take, then load a new result
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (err_load) begin
      out_valid_d  = 1'b1;
      out_data_d   = '0;
      out_last_d   = 1'b1;
      out_status_d = err_status;
    end else if (out_load) begin
      out_valid_d  = 1'b1;
      out_data_d   = osrr_pkg::TdataW'({SensW'(pend_pos_q), rd_values});
      out_last_d   = pend_last_q;
      out_status_d = osrr_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= osrr_pkg::S_IDLE;
      write_slot_q  <= '0;
      oldest_slot_q <= '0;
      count_q       <= '0;
      push_pos_q    <= '0;
      run_more_q    <= 1'b0;
      pend_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      write_slot_q  <= write_slot_d;
      oldest_slot_q <= oldest_slot_d;
      count_q       <= count_d;
      push_pos_q    <= push_pos_d;
      run_more_q    <= run_more_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_slot_q   <= run_slot_d;
    run_pos_q    <= run_pos_d;
    run_end_q    <= run_end_d;
    pend_pos_q   <= pend_pos_d;
    pend_last_q  <= pend_last_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  osrr_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_record_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

`include "overwriting_sensor_record_ring_assert.svh"

  `OSRR_ASSERT_ALWAYS(a_count_range, count_q <= CntW'(SLOTS), "committed count above ring size")
  `OSRR_ASSERT_SAME(a_no_overwrite, out_load || err_load, out_free, "result loaded over a held one")
  `OSRR_ASSERT_NEXT(a_run_ends, out_load && pend_last_q, state_q == osrr_pkg::S_IDLE && !pend_q, "run did not end after its final reading")
  `OSRR_ASSERT_NEXT(a_pop_count, accept && op == osrr_pkg::OP_POP && !is_empty, count_q == $past(count_q) - CntW'(1), "pop did not retire one measurement")

endmodule

>>> bench/overwriting_sensor_record_ring_tb.sv
// ----------------------------------------------------------------------------
// overwriting_sensor_record_ring_tb
// Self-checking bench for the sensor record ring. A scoreboard class keeps its
// own copy of the ring, turns every accepted request into the results it must
// cause, and compares each accepted result field by field against the oldest
// one pending. Stimulus opens with hand-picked corner requests, fills the ring
// past capacity so the oldest measurement is overwritten, then runs a random
// mix of whole, interrupted and cleared measurements, pops and gets, with
// random stalls on both stream sides.
// ----------------------------------------------------------------------------
module overwriting_sensor_record_ring_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TdataW       = osrr_pkg::TdataW;
  localparam int FieldW       = osrr_pkg::FieldW;
  localparam int SelW         = osrr_pkg::SelW;
  localparam int NumValues    = osrr_pkg::NumValues;
  localparam int StatusW      = osrr_pkg::StatusW;
  localparam int Slots        = 8;
  localparam int Sensors      = 17;
  localparam int ItemTarget   = 410;   // stop issuing random requests here
  localparam int QuietItems   = 60;    // final stretch without any stalls
  localparam int SettleCycles = 20;    // well past the get latency
  localparam int MaxPrinted   = 40;    // keep the log short on a broken block
  localparam int PadW         = TdataW - NumValues * FieldW - SelW;

  typedef logic [NumValues-1:0][FieldW-1:0] reading_t;

  typedef struct packed {
    reading_t          vals;
    logic [SelW-1:0]   sensor;
    logic              last;
    osrr_pkg::status_e status;
  } ring_result_t;

  // --------------------------------------------------------------------------
  // Ring predictor and result checker
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    reading_t     records [Slots][Sensors];
    int unsigned  wr_slot;
    int unsigned  old_slot;
    int unsigned  committed;
    int unsigned  push_pos;
    ring_result_t pending_q [$];
    int           errors;
    int           printed;

    function new();
      foreach (records[s, i]) records[s][i] = '0;
      wr_slot   = 0;
      old_slot  = 0;
      committed = 0;
      push_pos  = 0;
      errors    = 0;
      printed   = 0;
    endfunction

    function void add_result(reading_t vals, logic [SelW-1:0] sensor, logic last,
                             osrr_pkg::status_e status);
      ring_result_t r;
      r.vals   = vals;
      r.sensor = sensor;
      r.last   = last;
      r.status = status;
      pending_q = {pending_q, r};
    endfunction

    // Advance the predicted ring by one accepted request.
    function void note_request(osrr_pkg::op_e op, reading_t vals, logic [SelW-1:0] sel);
      case (op)
        osrr_pkg::OP_PUSH: begin
          // a full ring gives up its oldest measurement on a fresh push
          if (push_pos == 0 && committed == Slots) begin
            old_slot  = (old_slot + 1) % Slots;
            committed = Slots - 1;
          end
          records[wr_slot][push_pos] = vals;
          push_pos++;
          if (push_pos == Sensors) begin
            push_pos  = 0;
            wr_slot   = (wr_slot + 1) % Slots;
            committed++;
          end
        end
        osrr_pkg::OP_POP: begin
          if (committed == 0) begin
            add_result('0, '0, 1'b1, osrr_pkg::STATUS_EMPTY);
          end else begin
            for (int i = 0; i < Sensors; i++)
              add_result(records[old_slot][i], SelW'(i), i == Sensors - 1,
                         osrr_pkg::STATUS_OK);
            old_slot = (old_slot + 1) % Slots;
            committed--;
          end
        end
        osrr_pkg::OP_GET: begin
          // the index check wins over the empty check
          if (sel > Sensors - 1)
            add_result('0, '0, 1'b1, osrr_pkg::STATUS_BAD_INDEX);
          else if (committed == 0)
            add_result('0, '0, 1'b1, osrr_pkg::STATUS_EMPTY);
          else
            add_result(records[(wr_slot + Slots - 1) % Slots][sel], sel, 1'b1,
                       osrr_pkg::STATUS_OK);
        end
        default: begin
          // clear drops pointers and any partial push, data stays behind
          wr_slot   = 0;
          old_slot  = 0;
          committed = 0;
          push_pos  = 0;
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (printed < MaxPrinted) begin
        printed++;
        $display("%0t mismatch: %s", $realtime, msg);
      end
    endtask

    task check_result(logic [TdataW-1:0] tdata, logic tlast, logic [StatusW-1:0] tuser);
      ring_result_t    want;
      reading_t        got_vals;
      logic [SelW-1:0] got_sensor;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result tdata=%h tlast=%b tuser=%0d",
                         tdata, tlast, tuser));
        return;
      end
      want       = pending_q[0];
      pending_q.delete(0);
      got_vals   = tdata[NumValues*FieldW-1:0];
      got_sensor = tdata[NumValues*FieldW +: SelW];
      for (int j = 0; j < NumValues; j++)
        if (got_vals[j] !== want.vals[j])
          report($sformatf("value %0d got %h want %h", j, got_vals[j], want.vals[j]));
      if (got_sensor !== want.sensor)
        report($sformatf("sensor got %0d want %0d", got_sensor, want.sensor));
      if (tlast !== want.last)
        report($sformatf("tlast got %b want %b", tlast, want.last));
      if (tuser !== want.status)
        report($sformatf("status got %0d want %0d", tuser, want.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [TdataW-1:0]   s_axis_tdata_i  = '0;
  logic [1:0]          s_axis_tuser_i  = osrr_pkg::OP_PUSH;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [TdataW-1:0]   m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [StatusW-1:0]  m_axis_tuser_o;

  ring_scoreboard      sb = new();
  bit                  idle_on    = 1'b1;
  int                  items_sent = 0;
  int unsigned         stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  overwriting_sensor_record_ring i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // --------------------------------------------------------------------------
  // Result side: check every accepted result, stall in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    if (stall_left != 0)
      stall_left--;
    else if (idle_on && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 15);
    m_axis_tready_i <= (stall_left == 0);
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Present one request, hold it until accepted, then maybe go quiet for a burst.
  // Valid stays high into the next request unless a gap is taken.
  task automatic send_request(osrr_pkg::op_e op, reading_t vals, logic [SelW-1:0] sel);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{PadW{1'b0}}, sel, vals};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, vals, sel);
    items_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Mostly full-range random values, with the signed extremes mixed in.
  function automatic reading_t random_reading();
    reading_t r;
    for (int j = 0; j < NumValues; j++)
      case ($urandom_range(0, 7))
        0:       r[j] = 16'h7fff;
        1:       r[j] = 16'h8000;
        default: r[j] = 16'($urandom);
      endcase
    return r;
  endfunction

  // Mostly valid sensor numbers, some out of range.
  function automatic logic [SelW-1:0] random_sel();
    if ($urandom_range(0, 4) == 0)
      return SelW'($urandom_range(Sensors, 31));
    return SelW'($urandom_range(0, Sensors - 1));
  endfunction

  task automatic push_readings(int count);
    repeat (count) send_request(osrr_pkg::OP_PUSH, random_reading(), SelW'($urandom));
  endtask

  task automatic ask_reading(logic [SelW-1:0] sel);
    send_request(osrr_pkg::OP_GET, random_reading(), sel);
  endtask

  task automatic pop_oldest();
    send_request(osrr_pkg::OP_POP, random_reading(), SelW'($urandom));
  endtask

  task automatic clear_ring();
    send_request(osrr_pkg::OP_CLEAR, random_reading(), SelW'($urandom));
  endtask

  // Drop valid and hold off until the block has delivered everything pending.
  task automatic wait_for_results();
    if (sb.pending_q.size() != 0) begin
      s_axis_tvalid_i <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clk_i);
    end
  endtask

  // One random slice of traffic: whole measurements dominate so the ring fills
  // and wraps; interrupted pushes see a pop, a get or a clear in the middle.
  task automatic random_step();
    int unsigned pick;
    int unsigned part;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      push_readings(Sensors);
    end else if (pick < 52) begin
      part = $urandom_range(1, Sensors - 1);
      push_readings(part);
      case ($urandom_range(0, 2))
        0: clear_ring();
        1: begin
          pop_oldest();
          push_readings(Sensors - part);
        end
        default: begin
          ask_reading(random_sel());
          push_readings(Sensors - part);
        end
      endcase
    end else if (pick < 72) begin
      pop_oldest();
    end else if (pick < 95) begin
      ask_reading(random_sel());
    end else begin
      clear_ring();
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    reading_t                 vals;
    logic [3:0][FieldW-1:0]   extremes;
    extremes = {16'hffff, 16'h0000, 16'h8000, 16'h7fff};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty ring: pop and get report empty, a bad index wins over empty.
    pop_oldest();
    ask_reading(SelW'(0));
    ask_reading(SelW'(Sensors));
    ask_reading(SelW'(31));
    clear_ring();

    // One measurement built from the signed extremes, then read it back.
    for (int i = 0; i < Sensors; i++) begin
      for (int j = 0; j < NumValues; j++) vals[j] = extremes[(i + j) % 4];
      send_request(osrr_pkg::OP_PUSH, vals, SelW'(i));
    end
    ask_reading(SelW'(0));
    ask_reading(SelW'(Sensors - 1));
    ask_reading(SelW'(Sensors));
    pop_oldest();
    pop_oldest();

    // Fill past capacity so the oldest measurements get overwritten.
    repeat (Slots + 2) begin
      push_readings(Sensors);
      ask_reading(random_sel());
    end

    // Let the block drain completely before the next pops.
    wait_for_results();
    repeat (3) pop_oldest();

    while (items_sent < ItemTarget - QuietItems) random_step();

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    while (items_sent < ItemTarget) random_step();
    repeat (Slots + 1) pop_oldest();

    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
